// ===== hdl/color_pixel_normalize_threshold_top_assert.svh =====
// assertion macros for the color pixel normalize threshold block
// expects clk and rst_n in the scope of the module that uses them
`ifndef COLOR_PIXEL_NORMALIZE_THRESHOLD_TOP_ASSERT_SVH
`define COLOR_PIXEL_NORMALIZE_THRESHOLD_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CPNT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CPNT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cpnt_pkg.sv =====
// shared types and constants for the color pixel normalize threshold block
// no dependencies
package cpnt_pkg;

  localparam int PIX_W     = 8;
  localparam int NUM_CHAN  = 3;
  localparam int WORD_W    = 2 * PIX_W;
  localparam int DIV_STEPS = PIX_W;

  localparam logic [PIX_W-1:0] PIX_FULL     = 8'hFF;
  localparam logic [PIX_W-1:0] THRESH_RESET = 8'd110;
  localparam logic [PIX_W-1:0] DIV_ONE      = 8'd1;

  typedef struct packed {
    logic [PIX_W-1:0] chan_a;
    logic [PIX_W-1:0] chan_b;
    logic [PIX_W-1:0] chan_c;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_a;
    logic [PIX_W-1:0] out_b;
    logic [PIX_W-1:0] out_c;
  } pix_out_t;

  // one divider word per channel: upper half is the partial remainder,
  // lower half the dividend bits still to come, quotient bits shift in at the bottom
  typedef struct packed {
    logic [PIX_W-1:0]                divisor;
    logic [NUM_CHAN-1:0][WORD_W-1:0] word;
  } cpnt_cell_t;

endpackage

// ===== hdl/color_pixel_normalize_threshold_top.sv =====
// top level of the color pixel normalize threshold block
// depends on cpnt_pkg, cpnt_front, cpnt_cell and the assertion macro header
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   pixel   | in_valid in_ready in_data      | in
//   result  | out_valid out_ready out_data   | out
//   config  | cfg_wr_en cfg_wr_data          | in
//
// one pixel per clock while out_ready is high; the pipeline is the front stage plus
// eight divider cells, one quotient bit per cell for all three channels
// every stage has its own valid bit, so bubbles close up while out_ready is low
// and the block keeps taking pixels until the chain is full
// synchronous active-low reset clears the valid bits and sets the threshold to 110
`include "color_pixel_normalize_threshold_top_assert.svh"

module color_pixel_normalize_threshold_top import cpnt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pix_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pix_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [PIX_W-1:0] cfg_wr_data
);

  logic [PIX_W-1:0]     thr_r, thr_nxt;
  logic [DIV_STEPS:0]   stg_valid;
  logic [DIV_STEPS:0]   stg_ready;
  cpnt_cell_t           stg_data [DIV_STEPS+1];

  always_comb begin
    if (cfg_wr_en) begin
      thr_nxt = cfg_wr_data;
    end else begin
      thr_nxt = thr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  cpnt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (thr_r),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .up_data   (in_data),
    .dn_valid  (stg_valid[0]),
    .dn_ready  (stg_ready[0]),
    .dn_data   (stg_data[0])
  );

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    cpnt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_data  (stg_data[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_data  (stg_data[g+1])
    );
  end

  // last cell register is the output register
  assign stg_ready[DIV_STEPS] = out_ready;
  assign out_valid            = stg_valid[DIV_STEPS];
  assign out_data.out_a       = stg_data[DIV_STEPS].word[0][PIX_W-1:0];
  assign out_data.out_b       = stg_data[DIV_STEPS].word[1][PIX_W-1:0];
  assign out_data.out_c       = stg_data[DIV_STEPS].word[2][PIX_W-1:0];

  `CPNT_ASSERT_NOW(a_div_nonzero, stg_valid[0], stg_data[0].divisor != '0, "divisor is zero")
  `CPNT_ASSERT_NOW(a_rem_below_div, stg_valid[0], (stg_data[0].word[0][WORD_W-1:PIX_W] < stg_data[0].divisor) && (stg_data[0].word[1][WORD_W-1:PIX_W] < stg_data[0].divisor) && (stg_data[0].word[2][WORD_W-1:PIX_W] < stg_data[0].divisor), "quotient would overflow")
  `CPNT_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, stg_valid[0], "accepted pixel lost at front")
  `CPNT_ASSERT_NEXT(a_cfg_write, cfg_wr_en, thr_r == $past(cfg_wr_data), "threshold write lost")

endmodule

// ===== hdl/cpnt_front.sv =====
// front stage: channel max, sum, color test and divider setup
// depends on cpnt_pkg
module cpnt_front import cpnt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [PIX_W-1:0] threshold,
  input  logic             up_valid,
  output logic             up_ready,
  input  pix_in_t          up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output cpnt_cell_t       dn_data
);

  logic                        valid_r, valid_nxt;
  cpnt_cell_t                  data_r, data_nxt;
  logic                        load;
  logic [NUM_CHAN-1:0][PIX_W-1:0] chan;
  logic [PIX_W-1:0]            mx;
  logic [PIX_W+1:0]            sum;
  logic [11:0]                 sum5;
  logic [11:0]                 mx12;
  logic                        is_marker;
  logic                        do_stretch;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    chan[0] = up_data.chan_a;
    chan[1] = up_data.chan_b;
    chan[2] = up_data.chan_c;

    mx = chan[0];
    if (chan[1] > mx) mx = chan[1];
    if (chan[2] > mx) mx = chan[2];

    sum  = {2'b00, chan[0]} + {2'b00, chan[1]} + {2'b00, chan[2]};
    // 5*sum < 12*max is mean < 0.8*max without fractions
    sum5 = 12'({sum, 2'b00}) + 12'(sum);
    mx12 = 12'({mx, 3'b000}) + 12'({mx, 2'b00});

    is_marker  = (chan[0] == PIX_FULL);
    do_stretch = !is_marker && (mx > threshold) && (sum5 < mx12);

    data_nxt = '0;
    if (is_marker) begin
      // divide by one so the channels come out unchanged
      data_nxt.divisor = DIV_ONE;
      for (int i = 0; i < NUM_CHAN; i++) begin
        data_nxt.word[i] = {{PIX_W{1'b0}}, chan[i]};
      end
    end else if (do_stretch) begin
      data_nxt.divisor = mx;
      for (int i = 0; i < NUM_CHAN; i++) begin
        // c*255 as c*256 - c
        data_nxt.word[i] = {chan[i], {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, chan[i]};
      end
    end else begin
      data_nxt.divisor = DIV_ONE;
    end
  end

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else begin
      valid_nxt = valid_r && !dn_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== hdl/cpnt_cell.sv =====
// divider cell: one restoring quotient bit for every channel, then a register
// depends on cpnt_pkg
module cpnt_cell import cpnt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  cpnt_cell_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output cpnt_cell_t dn_data
);

  logic                          valid_r, valid_nxt;
  cpnt_cell_t                    data_r, data_nxt;
  logic                          load;
  logic [NUM_CHAN-1:0][PIX_W:0]  trial;
  logic [NUM_CHAN-1:0][PIX_W:0]  diff;
  logic [NUM_CHAN-1:0]           qbit;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    data_nxt.divisor = up_data.divisor;
    for (int i = 0; i < NUM_CHAN; i++) begin
      // remainder stays below the divisor, so the trial fits in 9 bits
      trial[i] = {up_data.word[i][WORD_W-1:PIX_W], up_data.word[i][PIX_W-1]};
      diff[i]  = trial[i] - {1'b0, up_data.divisor};
      qbit[i]  = (trial[i] >= {1'b0, up_data.divisor});
      if (qbit[i]) begin
        data_nxt.word[i] = {diff[i][PIX_W-1:0], up_data.word[i][PIX_W-2:0], 1'b1};
      end else begin
        data_nxt.word[i] = {trial[i][PIX_W-1:0], up_data.word[i][PIX_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else begin
      valid_nxt = valid_r && !dn_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== tb/cpnt_pixel_compare.sv =====
// scoreboard for the color pixel normalize threshold block: tracks the threshold
// register, predicts each result pixel and compares the result stream
// depends on cpnt_pkg
module cpnt_pixel_compare import cpnt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  pix_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  pix_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [PIX_W-1:0] cfg_wr_data,
  output int               pending,
  output int               fail_count
);

  pix_out_t         expected_pixels[$];
  logic [PIX_W-1:0] color_thresh = THRESH_RESET;
  int               mismatches = 0;
  string            chan_label [NUM_CHAN] = '{"out_c", "out_b", "out_a"};

  // marker pass, stretch to full scale, or blank
  function automatic pix_out_t normalize_pixel(input pix_in_t px,
                                               input logic [PIX_W-1:0] thr);
    logic [PIX_W-1:0] peak;
    int unsigned      total;
    pix_out_t         res;
    if (px.chan_a == PIX_FULL) begin
      return pix_out_t'(px);
    end
    peak = px.chan_a;
    if (px.chan_b > peak) peak = px.chan_b;
    if (px.chan_c > peak) peak = px.chan_c;
    total = int'(px.chan_a) + int'(px.chan_b) + int'(px.chan_c);
    res = '0;
    // mean below 0.8 of the peak, kept in integers
    if (peak > thr && 5 * total < 12 * int'(peak)) begin
      res.out_a = PIX_W'(int'(px.chan_a) * 255 / int'(peak));
      res.out_b = PIX_W'(int'(px.chan_b) * 255 / int'(peak));
      res.out_c = PIX_W'(int'(px.chan_c) * 255 / int'(peak));
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pix_out_t                        want;
    logic [NUM_CHAN-1:0][PIX_W-1:0]  want_ch;
    logic [NUM_CHAN-1:0][PIX_W-1:0]  got_ch;
    if (!rst_n) begin
      color_thresh = THRESH_RESET;
      expected_pixels.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_pixels.push_back(normalize_pixel(in_data, color_thresh));
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer %h with no pixel pending", $time, out_data);
        end else begin
          want    = expected_pixels.pop_front();
          want_ch = want;
          got_ch  = out_data;
          for (int k = NUM_CHAN - 1; k >= 0; k--) begin
            if (want_ch[k] !== got_ch[k]) begin
              mismatches++;
              $display("%0t: %s expected %0d got %0d", $time, chan_label[k],
                       want_ch[k], got_ch[k]);
            end
          end
        end
      end
      if (cfg_wr_en) begin
        color_thresh = cfg_wr_data;
      end
    end
    pending    <= expected_pixels.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/color_pixel_normalize_threshold_top_test.sv =====
// stimulus and verdict for the color pixel normalize threshold block
// depends on cpnt_pkg, color_pixel_normalize_threshold_top and cpnt_pixel_compare
module color_pixel_normalize_threshold_top_test;
  import cpnt_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int DRAIN_CYCLES  = 12;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 250;
  localparam int LIMIT_CYCLES  = 400000;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;
  typedef enum int {PK_MARKER, PK_COLOR, PK_EDGE, PK_NOISE} pix_kind_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  pix_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  pix_out_t         out_data;
  logic             cfg_wr_en = 1'b0;
  logic [PIX_W-1:0] cfg_wr_data = '0;
  int               pending;
  int               fail_count;

  int               burst_left = 0;
  logic [PIX_W-1:0] cur_thresh = THRESH_RESET;
  rx_mode_t         rx_mode = RX_OPEN;
  int               mode_left = 0;
  int unsigned      beat = 0;

  color_pixel_normalize_threshold_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  cpnt_pixel_compare scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // receiver switches at random between stall patterns: open, mostly ready, sparse, periodic
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(64, 256);
    end else begin
      mode_left <= mode_left - 1;
    end
    beat <= beat + 1;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (beat[2:0] != 3'd0);
    endcase
  end

  task automatic send_pixel(input pix_in_t px);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_threshold(input logic [PIX_W-1:0] thr);
    wait_empty();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= thr;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    cur_thresh = thr;
  endtask

  // random pixels: some with a peak at or just above the threshold, some whose sum sits near
  // the colorfulness boundary, plus markers and raw noise
  function automatic pix_in_t random_pixel(input logic [PIX_W-1:0] thr);
    pix_kind_t        kind;
    int unsigned      pick;
    int unsigned      peak;
    int unsigned      rest;
    int unsigned      lo_x;
    int unsigned      hi_x;
    int unsigned      x;
    int unsigned      y;
    int               slot;
    logic [PIX_W-1:0] ch [3];
    pick = $urandom_range(0, 99);
    kind = (pick < 15) ? PK_MARKER : (pick < 60) ? PK_COLOR :
           (pick < 80) ? PK_EDGE : PK_NOISE;
    if (kind == PK_MARKER) begin
      return {PIX_FULL, PIX_W'($urandom), PIX_W'($urandom)};
    end
    if (kind == PK_NOISE) begin
      return pix_in_t'(24'($urandom));
    end
    if ($urandom_range(0, 3) == 0) begin
      peak = int'(thr) + $urandom_range(0, 1);
      if (peak > 255) peak = 255;
      if (peak == 0) peak = 1;
    end else begin
      peak = $urandom_range(1, 255);
    end
    if (kind == PK_COLOR) begin
      x = $urandom_range(0, peak);
      y = $urandom_range(0, peak);
    end else begin
      // other two channels sum to just below, at or just above the boundary
      rest = (12 * peak) / 5 - peak + $urandom_range(0, 2) - 1;
      if (rest > 2 * peak) rest = 2 * peak;
      lo_x = (rest > peak) ? rest - peak : 0;
      hi_x = (rest < peak) ? rest : peak;
      x    = $urandom_range(lo_x, hi_x);
      y    = rest - x;
    end
    ch[0] = PIX_W'(peak);
    ch[1] = PIX_W'(x);
    ch[2] = PIX_W'(y);
    slot  = $urandom_range(0, 2);
    return {ch[slot], ch[(slot + 1) % 3], ch[(slot + 2) % 3]};
  endfunction

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [PIX_W-1:0] thr;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset threshold of 110
    send_pixel({8'd255, 8'd0,   8'd0});
    send_pixel({8'd255, 8'd255, 8'd255});
    send_pixel({8'd255, 8'd17,  8'd200});
    send_pixel({8'd0,   8'd0,   8'd0});
    send_pixel({8'd254, 8'd0,   8'd0});
    send_pixel({8'd0,   8'd255, 8'd0});
    send_pixel({8'd0,   8'd0,   8'd255});
    send_pixel({8'd110, 8'd0,   8'd0});    // peak equal to threshold
    send_pixel({8'd111, 8'd0,   8'd0});
    send_pixel({8'd200, 8'd200, 8'd80});   // 5*sum exactly 12*peak
    send_pixel({8'd200, 8'd200, 8'd79});
    send_pixel({8'd120, 8'd120, 8'd120});  // gray
    send_pixel({8'd128, 8'd64,  8'd32});
    send_pixel({8'd1,   8'd2,   8'd200});
    send_pixel({8'd254, 8'd254, 8'd0});
    send_pixel({8'd0,   8'd250, 8'd250});
    send_pixel({8'd170, 8'd85,  8'd1});
    send_pixel({8'd100, 8'd50,  8'd25});

    set_threshold(8'd0);
    send_pixel({8'd1,   8'd0,   8'd0});
    send_pixel({8'd0,   8'd0,   8'd0});
    set_threshold(8'd255);
    send_pixel({8'd0,   8'd255, 8'd0});
    send_pixel({8'd255, 8'd3,   8'd9});
    set_threshold(8'd254);
    send_pixel({8'd0,   8'd255, 8'd0});
    send_pixel({8'd254, 8'd1,   8'd0});

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        2:       thr = THRESH_RESET;
        3:       thr = 8'd1;
        default: thr = PIX_W'($urandom_range(0, 255));
      endcase
      set_threshold(thr);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_pixel(random_pixel(cur_thresh));
      end
    end

    wait_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
